### src/assert_macros.svh
// assertion macros used by aisb_merge
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AISB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AISB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/aisb_pkg.sv
// package for the inverse byte substitution core: types, constants, gf helpers
// no dependencies
package aisb_pkg;

  localparam int unsigned NUM_LANES   = 16;
  localparam int unsigned HALF_LANES  = NUM_LANES / 2;
  localparam int unsigned WORD_W      = 64;
  localparam logic [8:0]  GF_POLY     = 9'h11B;
  localparam logic [7:0]  AFFINE_C    = 8'h05;

  typedef logic [7:0]              byte_t;
  typedef logic [WORD_W-1:0]       half_t;
  typedef logic [255:0][7:0]       gf_tbl_t;
  typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

  function automatic byte_t inv_affine(input byte_t b);
    return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ AFFINE_C;
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [8:0] x;
    byte_t      y;
    byte_t      acc;
    x   = {1'b0, a};
    y   = b;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) begin
        acc = acc ^ x[7:0];
      end
      y = y >> 1;
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // a^254 for every element, zero maps to zero
  function automatic gf_tbl_t build_gf_inv_tbl();
    gf_tbl_t tbl;
    byte_t   r;
    byte_t   base;
    byte_t   e;
    for (int a = 0; a < 256; a++) begin
      r    = 8'h01;
      base = 8'(a);
      e    = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[0]) begin
          r = gf_mul(r, base);
        end
        base = gf_mul(base, base);
        e    = e >> 1;
      end
      tbl[a] = (a == 0) ? 8'h00 : r;
    end
    return tbl;
  endfunction

  localparam gf_tbl_t GF_INV_TBL = build_gf_inv_tbl();

endpackage

### src/aisb_lane.sv
// one byte lane: inverse affine transform then gf(2^8) inverse lookup
// depends on aisb_pkg
module aisb_lane (
  input  aisb_pkg::byte_t in_byte,
  output aisb_pkg::byte_t out_byte
);
  import aisb_pkg::*;

  byte_t aff;

  assign aff      = inv_affine(in_byte);
  assign out_byte = GF_INV_TBL[aff];

endmodule

### src/aisb_merge.sv
// merging stage: packs the lane bytes into the result word and holds it in the output register
// depends on aisb_pkg and assert_macros.svh
module aisb_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aisb_pkg::lane_bytes_t lane_bytes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aisb_pkg::half_t       out_result_low,
  output aisb_pkg::half_t       out_result_high
);
  import aisb_pkg::*;
  `include "assert_macros.svh"

  logic  valid_r;
  logic  valid_nxt;
  half_t low_r;
  half_t high_r;
  logic  in_fire;
  logic  out_fire;

  assign in_ready = !valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = valid_r && out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (out_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      low_r  <= lane_bytes[HALF_LANES-1:0];
      high_r <= lane_bytes[NUM_LANES-1:HALF_LANES];
    end
  end

  assign out_valid       = valid_r;
  assign out_result_low  = low_r;
  assign out_result_high = high_r;

  `AISB_ASSERT_NXT(a_fire_fills, clk, rst_n, in_fire, valid_r)
  `AISB_ASSERT_IMP(a_stall_only_full, clk, rst_n, !in_ready, valid_r && !out_ready)
  `AISB_ASSERT_NXT(a_drain_empties, clk, rst_n, out_fire && !in_fire, !valid_r)

endmodule

### src/aes_inverse_sub_bytes_core.sv
// aes inverse byte substitution: one 128-bit state word per cycle unless the output stalls.
// sixteen byte lanes each apply the inverse affine transform and a gf(2^8) inverse
// table lookup; the merging stage registers the packed result behind a valid/ready
// output register, so a new word is taken every cycle while the previous result is
// being taken. depends on aisb_pkg, aisb_lane, aisb_merge.
module aes_inverse_sub_bytes_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  aisb_pkg::half_t in_state_low,
  input  aisb_pkg::half_t in_state_high,
  output logic            out_valid,
  input  logic            out_ready,
  output aisb_pkg::half_t out_result_low,
  output aisb_pkg::half_t out_result_high
);
  import aisb_pkg::*;

  lane_bytes_t state_bytes;
  lane_bytes_t sub_bytes;

  assign state_bytes = {in_state_high, in_state_low};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    aisb_lane u_lane (
      .in_byte  (state_bytes[g]),
      .out_byte (sub_bytes[g])
    );
  end

  aisb_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .lane_bytes      (sub_bytes),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high)
  );

endmodule
